// ===== rtl/tesq_pkg.sv =====
`default_nettype none

package tesq_pkg;

  // fixed field widths of one item
  localparam int unsigned ClassW  = 12;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned DelayW  = 16;
  localparam int unsigned TagW    = 16;
  localparam int unsigned LenW    = 13;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned StatusW = 2;

  // command codes
  localparam logic CMD_QUEUE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRE   = 1'b1;

  // queue status codes
  localparam logic [StatusW-1:0] STATUS_STORED  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EVICTED = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL    = 2'd2;
  localparam logic [StatusW-1:0] STATUS_SKIPPED = 2'd3;

  typedef struct packed {
    logic              cmd;
    logic              reliable;
    logic [ClassW-1:0] class_index;
    logic [DelayW-1:0] delay_ticks;
    logic [TagW-1:0]   payload_tag;
    logic [LenW-1:0]   length_bits;
    logic [TimeW-1:0]  now_time;
    logic              link_down;
    logic              demo_skipping;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot;
    logic [ClassW-1:0]  class_id;
    logic [TagW-1:0]    out_payload_tag;
    logic [LenW-1:0]    out_length_bits;
    logic               last;
  } res_item_t;

  // classified command handed from the front to the back
  typedef enum logic [1:0] {
    OP_QUEUE,
    OP_DROP,
    OP_TICK,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              reliable;
    logic [ClassW-1:0] cls;
    logic [TimeW-1:0]  tval;   // fire time for a queue, current time for a tick
    logic [TagW-1:0]   pay;
    logic [LenW-1:0]   len;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND_EMPTY,
    ST_FIND_EVICT,
    ST_TICK,
    ST_FLUSH
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/timed_event_slot_queue_top.sv =====
// queue item: one status item, set by the slot scans
// tick item: fired items trail the slot walk, the last of them marked last
// flow: the back takes one item at a time; a two-entry command queue keeps busy low
// during a walk until it fills; the receiver cannot stall results
// reset: asynchronous active low, all slots empty and the command queue cleared
`default_nettype none

module timed_event_slot_queue_top import tesq_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 64,
  parameter int unsigned CLASS_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item_i,
  output logic      res_valid_o,
  output res_item_t res_item_o
);

  // front to queue
  logic fifo_full;
  logic push;
  cmd_t push_cmd;

  // queue to back
  logic fifo_valid;
  logic pop;
  cmd_t pop_cmd;

  // front: takes an item when start is high and the queue has room,
  // sorts it into queue, skip drop, tick or disconnect clear and forms the fire time
  tesq_front #(
    .CLASS_BITS (CLASS_BITS)
  ) u_front (
    .start_i     (start),
    .in_item_i   (in_item_i),
    .fifo_full_i (fifo_full),
    .busy_o      (busy),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // short command queue so the front keeps taking items during a walk
  tesq_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .cmd_o   (pop_cmd)
  );

  // back: slot table, empty and eviction scans, tick walk and result strobe
  tesq_back #(
    .SLOT_COUNT (SLOT_COUNT),
    .CLASS_BITS (CLASS_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (pop),
    .res_valid_o (res_valid_o),
    .res_item_o  (res_item_o)
  );

endmodule

`default_nettype wire

// ===== rtl/tesq_front.sv =====
`default_nettype none

module tesq_front import tesq_pkg::*; #(
  parameter int unsigned CLASS_BITS = 12
) (
  input  logic     start_i,
  input  in_item_t in_item_i,
  input  logic     fifo_full_i,
  output logic     busy_o,
  output logic     push_o,
  output cmd_t     cmd_o
);

  localparam int unsigned KeepW = (CLASS_BITS < ClassW) ? CLASS_BITS : ClassW;
  localparam logic [ClassW-1:0] ClassMask = {ClassW{1'b1}} >> (ClassW - KeepW);

  assign busy_o = fifo_full_i;
  assign push_o = start_i & ~fifo_full_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.reliable = in_item_i.reliable;
    cmd_o.cls      = in_item_i.class_index & ClassMask;
    cmd_o.pay      = in_item_i.payload_tag;
    cmd_o.len      = in_item_i.length_bits;
    priority if (in_item_i.cmd == CMD_TICK) begin
      cmd_o.op   = in_item_i.link_down ? OP_CLEAR : OP_TICK;
      cmd_o.tval = in_item_i.now_time;
    end else if (!in_item_i.reliable && in_item_i.demo_skipping) begin
      cmd_o.op = OP_DROP;
    end else begin
      cmd_o.op = OP_QUEUE;
      // zero delay means due at the next tick, marked by fire time zero
      if (in_item_i.delay_ticks == '0) begin
        cmd_o.tval = '0;
      end else begin
        cmd_o.tval = in_item_i.now_time + TimeW'(in_item_i.delay_ticks);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tesq_cmd_fifo.sv =====
`default_nettype none

module tesq_cmd_fifo import tesq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + PtrW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tesq_back.sv =====
`default_nettype none

module tesq_back import tesq_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 64,
  parameter int unsigned CLASS_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      res_valid_o,
  output res_item_t res_item_o
);

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned ClsW = (CLASS_BITS < ClassW) ? CLASS_BITS : ClassW;
  localparam logic [IdxW-1:0] LastSlot = IdxW'(SLOT_COUNT - 1);
  localparam logic [CntW-1:0] SlotCnt  = CntW'(SLOT_COUNT);

  typedef struct packed {
    logic             rel;
    logic [ClsW-1:0]  cls;
    logic [TimeW-1:0] fire;
    logic [TagW-1:0]  pay;
    logic [LenW-1:0]  len;
  } entry_t;

  function automatic res_item_t status_item(logic [StatusW-1:0] st, logic [SlotW-1:0] sl);
    res_item_t r;
    r        = '0;
    r.kind   = KIND_STATUS;
    r.status = st;
    r.slot   = sl;
    r.last   = 1'b1;
    return r;
  endfunction

  back_state_e     state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            rd_vld_q, rd_vld_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            rd_occ_q;
  entry_t          rd_q;
  logic [SLOT_COUNT-1:0] occ_q, occ_d;
  logic            pend_vld_q, pend_vld_d;
  res_item_t       pend_q, pend_d;
  logic            res_vld_q, res_vld_d;
  res_item_t       res_q, res_d;

  entry_t          mem [SLOT_COUNT];
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [IdxW-1:0] raddr;
  entry_t          wdata;
  logic            issue;
  logic            due;
  res_item_t       fire_res;

  assign raddr       = idx_q[IdxW-1:0];
  assign res_valid_o = res_vld_q;
  assign res_item_o  = res_q;

  always_comb begin
    wdata.rel  = cmd_q.reliable;
    wdata.cls  = cmd_q.cls[ClsW-1:0];
    wdata.fire = cmd_q.tval;
    wdata.pay  = cmd_q.pay;
    wdata.len  = cmd_q.len;

    due = (rd_q.fire == '0) || (rd_q.fire <= cmd_q.tval);

    fire_res                 = '0;
    fire_res.kind            = KIND_FIRE;
    fire_res.status          = STATUS_STORED;
    fire_res.slot            = SlotW'(rd_idx_q);
    fire_res.class_id        = ClassW'(rd_q.cls) - ClassW'(1);
    fire_res.out_payload_tag = rd_q.pay;
    fire_res.out_length_bits = rd_q.len;
    fire_res.last            = 1'b0;
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    occ_d      = occ_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    res_vld_d  = 1'b0;
    res_d      = res_q;
    cmd_pop_o  = 1'b0;
    we         = 1'b0;
    waddr      = idx_q[IdxW-1:0];
    issue      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = '0;
          unique case (cmd_i.op)
            OP_DROP: begin
              res_vld_d = 1'b1;
              res_d     = status_item(STATUS_SKIPPED, '0);
            end
            OP_CLEAR: begin
              occ_d = '0;
            end
            OP_QUEUE: begin
              state_d = ST_FIND_EMPTY;
            end
            OP_TICK: begin
              pend_vld_d = 1'b0;
              state_d    = ST_TICK;
            end
          endcase
        end
      end

      ST_FIND_EMPTY: begin
        priority if (!occ_q[idx_q[IdxW-1:0]]) begin
          we                       = 1'b1;
          waddr                    = idx_q[IdxW-1:0];
          occ_d[idx_q[IdxW-1:0]]   = |wdata.cls;
          res_vld_d                = 1'b1;
          res_d                    = status_item(STATUS_STORED, SlotW'(idx_q[IdxW-1:0]));
          state_d                  = ST_IDLE;
        end else if (idx_q[IdxW-1:0] == LastSlot) begin
          if (cmd_q.reliable) begin
            idx_d   = '0;
            state_d = ST_FIND_EVICT;
          end else begin
            res_vld_d = 1'b1;
            res_d     = status_item(STATUS_FULL, '0);
            state_d   = ST_IDLE;
          end
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end

      ST_FIND_EVICT: begin
        priority if (rd_vld_q && !rd_q.rel) begin
          we              = 1'b1;
          waddr           = rd_idx_q;
          occ_d[rd_idx_q] = |wdata.cls;
          res_vld_d       = 1'b1;
          res_d           = status_item(STATUS_EVICTED, SlotW'(rd_idx_q));
          state_d         = ST_IDLE;
        end else if (rd_vld_q && rd_idx_q == LastSlot) begin
          res_vld_d = 1'b1;
          res_d     = status_item(STATUS_FULL, '0);
          state_d   = ST_IDLE;
        end else begin
          issue = 1'b1;
        end
      end

      ST_TICK: begin
        issue = 1'b1;
        // one fired result is held back until it is known whether it is the last
        if (rd_vld_q && rd_occ_q && due) begin
          occ_d[rd_idx_q] = 1'b0;
          if (pend_vld_q) begin
            res_vld_d = 1'b1;
            res_d     = pend_q;
          end
          pend_vld_d = 1'b1;
          pend_d     = fire_res;
        end
        if (rd_vld_q && rd_idx_q == LastSlot) begin
          state_d = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        if (pend_vld_q) begin
          res_vld_d  = 1'b1;
          res_d      = pend_q;
          res_d.last = 1'b1;
        end
        pend_vld_d = 1'b0;
        state_d    = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // walk pointer: one slot read issued per cycle
    if (issue && idx_q != SlotCnt) begin
      rd_vld_d = 1'b1;
      rd_idx_d = idx_q[IdxW-1:0];
      idx_d    = idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      rd_vld_q   <= 1'b0;
      occ_q      <= '0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      rd_vld_q   <= rd_vld_d;
      occ_q      <= occ_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    rd_idx_q <= rd_idx_d;
    pend_q   <= pend_d;
    res_q    <= res_d;
    rd_occ_q <= occ_q[raddr];
  end

  // slot table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  a_fire_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.kind == KIND_FIRE) |->
      ($past(state_q) == ST_TICK || $past(state_q) == ST_FLUSH))
    else $error("fired item outside a tick walk");

  a_evict_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIND_EVICT) |-> (&occ_q))
    else $error("eviction search with an empty slot");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.kind == KIND_STATUS) |-> res_q.last)
    else $error("status item without last");

  a_pend_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_vld_q)
    else $error("held fired item left after walk");

endmodule

`default_nettype wire
